FILE: hdl/i2cts_pkg.sv
// Shared types and constants for the I2C transaction slave model.
// No dependencies; used by i2cts_engine and the top level.
package i2cts_pkg;

    // Bus event codes carried on s_tuser
    localparam logic [2:0] FN_START   = 3'd0;
    localparam logic [2:0] FN_RESTART = 3'd1;
    localparam logic [2:0] FN_STOP    = 3'd2;
    localparam logic [2:0] FN_ADDRESS = 3'd3;
    localparam logic [2:0] FN_WRITE   = 3'd4;
    localparam logic [2:0] FN_READ    = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_BYTE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_DFLT  = 2'd2;
    localparam int unsigned CFG_DATA_W = 8;

    // Stream widths
    localparam int unsigned FUNC_W     = 3;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned CNT_OUT_W  = 32;
    localparam int unsigned M_TDATA_W  = 216;
    localparam int unsigned M_USED_W   = 18 + 6 * CNT_OUT_W;

    // One registered bus event
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [7:0]        target_address;
        logic              read_not_write;
        logic [7:0]        write_data;
        logic              master_nack;
    } event_t;

    // Result of one event, counters already cut to the output width
    typedef struct packed {
        logic                 accepted;
        logic                 slave_nack;
        logic [7:0]           rd_byte;
        logic [7:0]           held_byte;
        logic [CNT_OUT_W-1:0] starts;
        logic [CNT_OUT_W-1:0] restarts;
        logic [CNT_OUT_W-1:0] stops;
        logic [CNT_OUT_W-1:0] acks;
        logic [CNT_OUT_W-1:0] nacks;
        logic [CNT_OUT_W-1:0] bytes;
    } result_t;

endpackage

FILE: hdl/i2cts_engine.sv
// Transaction state, legality checks and event counters of the slave model.
// Depends on i2cts_pkg; instantiated by i2c_transaction_slave_model_core.
module i2cts_engine #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  i2cts_pkg::event_t   ev,
    input  logic [6:0]          slave_address,
    input  logic [7:0]          slave_read_byte,
    input  logic                rx_load,
    input  logic [7:0]          rx_load_data,
    output i2cts_pkg::result_t  rslt
);

    localparam int CW = COUNTER_WIDTH;
    localparam int OW = i2cts_pkg::CNT_OUT_W;

    logic          bus_active_reg, bus_active_next;
    logic          matched_reg, matched_next;
    logic [6:0]    target_reg, target_next;
    logic          is_read_reg, is_read_next;
    logic [7:0]    rx_byte_reg, rx_byte_next;
    logic [CW-1:0] start_cnt_reg, start_cnt_next;
    logic [CW-1:0] restart_cnt_reg, restart_cnt_next;
    logic [CW-1:0] stop_cnt_reg, stop_cnt_next;
    logic [CW-1:0] ack_cnt_reg, ack_cnt_next;
    logic [CW-1:0] nack_cnt_reg, nack_cnt_next;
    logic [CW-1:0] byte_cnt_reg, byte_cnt_next;

    logic          ok;
    logic          snack;
    logic [7:0]    rdata;
    logic          data_phase_ok;

    // Data phases need a live, matched transaction still pointing at us
    assign data_phase_ok = bus_active_reg && matched_reg && (target_reg == slave_address);

    // Event decode and next state
    always_comb
    begin
        bus_active_next  = bus_active_reg;
        matched_next     = matched_reg;
        target_next      = target_reg;
        is_read_next     = is_read_reg;
        rx_byte_next     = rx_byte_reg;
        start_cnt_next   = start_cnt_reg;
        restart_cnt_next = restart_cnt_reg;
        stop_cnt_next    = stop_cnt_reg;
        ack_cnt_next     = ack_cnt_reg;
        nack_cnt_next    = nack_cnt_reg;
        byte_cnt_next    = byte_cnt_reg;
        ok               = 1'b0;
        snack            = 1'b0;
        rdata            = 8'd0;

        if (step)
        begin
            unique case (ev.func)
                i2cts_pkg::FN_START:
                begin
                    if (!bus_active_reg)
                    begin
                        bus_active_next = 1'b1;
                        matched_next    = 1'b0;
                        target_next     = 7'd0;
                        is_read_next    = 1'b0;
                        start_cnt_next  = start_cnt_reg + CW'(1);
                        ok              = 1'b1;
                    end
                end
                i2cts_pkg::FN_RESTART:
                begin
                    if (bus_active_reg)
                    begin
                        matched_next     = 1'b0;
                        target_next      = 7'd0;
                        is_read_next     = 1'b0;
                        restart_cnt_next = restart_cnt_reg + CW'(1);
                        ok               = 1'b1;
                    end
                end
                i2cts_pkg::FN_STOP:
                begin
                    if (bus_active_reg)
                    begin
                        bus_active_next = 1'b0;
                        matched_next    = 1'b0;
                        target_next     = 7'd0;
                        is_read_next    = 1'b0;
                        stop_cnt_next   = stop_cnt_reg + CW'(1);
                        ok              = 1'b1;
                    end
                end
                i2cts_pkg::FN_ADDRESS:
                begin
                    // 8-bit addresses beyond the 7-bit space are refused
                    if (bus_active_reg && !ev.target_address[7])
                    begin
                        byte_cnt_next = byte_cnt_reg + CW'(1);
                        target_next   = ev.target_address[6:0];
                        is_read_next  = ev.read_not_write;
                        if (ev.target_address[6:0] == slave_address)
                        begin
                            matched_next = 1'b1;
                            ack_cnt_next = ack_cnt_reg + CW'(1);
                        end
                        else
                        begin
                            matched_next  = 1'b0;
                            nack_cnt_next = nack_cnt_reg + CW'(1);
                            snack         = 1'b1;
                        end
                        ok = 1'b1;
                    end
                end
                i2cts_pkg::FN_WRITE:
                begin
                    if (data_phase_ok && !is_read_reg)
                    begin
                        rx_byte_next  = ev.write_data;
                        byte_cnt_next = byte_cnt_reg + CW'(1);
                        ack_cnt_next  = ack_cnt_reg + CW'(1);
                        ok            = 1'b1;
                    end
                end
                i2cts_pkg::FN_READ:
                begin
                    if (data_phase_ok && is_read_reg)
                    begin
                        rdata         = slave_read_byte;
                        byte_cnt_next = byte_cnt_reg + CW'(1);
                        if (ev.master_nack)
                            nack_cnt_next = nack_cnt_reg + CW'(1);
                        else
                            ack_cnt_next = ack_cnt_reg + CW'(1);
                        ok = 1'b1;
                    end
                end
                default:
                begin
                    // unused codes are rejected
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_active_reg  <= 1'b0;
            matched_reg     <= 1'b0;
            target_reg      <= 7'd0;
            is_read_reg     <= 1'b0;
            rx_byte_reg     <= 8'd0;
            start_cnt_reg   <= '0;
            restart_cnt_reg <= '0;
            stop_cnt_reg    <= '0;
            ack_cnt_reg     <= '0;
            nack_cnt_reg    <= '0;
            byte_cnt_reg    <= '0;
        end
        else
        begin
            bus_active_reg  <= bus_active_next;
            matched_reg     <= matched_next;
            target_reg      <= target_next;
            is_read_reg     <= is_read_next;
            rx_byte_reg     <= rx_load ? rx_load_data : rx_byte_next;
            start_cnt_reg   <= start_cnt_next;
            restart_cnt_reg <= restart_cnt_next;
            stop_cnt_reg    <= stop_cnt_next;
            ack_cnt_reg     <= ack_cnt_next;
            nack_cnt_reg    <= nack_cnt_next;
            byte_cnt_reg    <= byte_cnt_next;
        end
    end

    // Result reports the state after the event
    always_comb
    begin
        rslt.accepted    = ok;
        rslt.slave_nack  = snack;
        rslt.rd_byte     = rdata;
        rslt.held_byte   = rx_byte_next;
        rslt.starts      = OW'(start_cnt_next);
        rslt.restarts    = OW'(restart_cnt_next);
        rslt.stops       = OW'(stop_cnt_next);
        rslt.acks        = OW'(ack_cnt_next);
        rslt.nacks       = OW'(nack_cnt_next);
        rslt.bytes       = OW'(byte_cnt_next);
    end

endmodule

FILE: hdl/i2c_transaction_slave_model_core.sv
// Top level of the I2C transaction slave model: stream ports, config registers,
// input and result registers. Depends on i2cts_pkg and i2cts_engine.
//
//  Channel   Direction  Transfer condition       Contents
//  s_*       in         s_tvalid & s_tready      one bus event (func on s_tuser)
//  m_*       out        m_tvalid & m_tready      one result per event
//  cfg_*     in         cfg_wr_en                register write, no read-back
//
// One event per clock while m_tready stays high; each event passes through the
// input register and then the result register before it appears on m_*.
// rst_n clears the transaction state, all counters and both valid flags.
// A stall on m_tready holds the result; s_tready drops only when both the
// input and result registers are full.
module i2c_transaction_slave_model_core #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // event input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [7:0] target_address, [8] read_not_write, [16:9] write_data,
    // [17] master_nack, [23:18] zero
    input  logic [i2cts_pkg::S_TDATA_W-1:0]      s_tdata,
    // [2:0] func
    input  logic [i2cts_pkg::FUNC_W-1:0]         s_tuser,
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] accepted, [1] slave_nack, [9:2] byte read, [17:10] last byte received,
    // [49:18] starts_seen, [81:50] restarts_seen, [113:82] stops_seen,
    // [145:114] acks_seen, [177:146] nacks_seen, [209:178] bytes_seen,
    // [215:210] zero
    output logic [i2cts_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [i2cts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [i2cts_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                 in_valid_reg;
    i2cts_pkg::event_t    ev_reg;
    logic                 out_valid_reg;
    i2cts_pkg::result_t   out_reg;
    logic [6:0]           slave_addr_reg;
    logic [7:0]           read_byte_reg;
    logic                 advance;
    logic                 step;
    logic                 rx_load;
    i2cts_pkg::result_t   rslt;

    // Handshake: result register frees when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    assign rx_load = cfg_wr_en && (cfg_index == i2cts_pkg::CFG_STORED_DFLT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= 7'd0;
            read_byte_reg  <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                i2cts_pkg::CFG_SLAVE_ADDR: slave_addr_reg <= cfg_data[6:0];
                i2cts_pkg::CFG_READ_BYTE:  read_byte_reg  <= cfg_data;
                default:
                begin
                    // stored byte default goes straight into the engine
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ev_reg.func           <= s_tuser;
            ev_reg.target_address <= s_tdata[7:0];
            ev_reg.read_not_write <= s_tdata[8];
            ev_reg.write_data     <= s_tdata[16:9];
            ev_reg.master_nack    <= s_tdata[17];
        end
    end

    // Transaction engine
    i2cts_engine #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .ev              (ev_reg),
        .slave_address   (slave_addr_reg),
        .slave_read_byte (read_byte_reg),
        .rx_load         (rx_load),
        .rx_load_data    (cfg_data),
        .rslt            (rslt)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= rslt;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        {(i2cts_pkg::M_TDATA_W - i2cts_pkg::M_USED_W){1'b0}},
        out_reg.bytes,
        out_reg.nacks,
        out_reg.acks,
        out_reg.stops,
        out_reg.restarts,
        out_reg.starts,
        out_reg.held_byte,
        out_reg.rd_byte,
        out_reg.slave_nack,
        out_reg.accepted
    };

    // A stepped event always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n) step |=> m_tvalid)
        else $error("stepped event did not produce a result");

    // Input back-pressure only arises from a stalled, full result stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // A rejected event reports no slave response and no read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && !rslt.accepted) |-> (!rslt.slave_nack && rslt.rd_byte == 8'd0))
        else $error("rejected event carries response fields");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for i2c_transaction_slave_model_core: directed and random bus events,
// each result checked against an in-bench transaction predictor. Needs i2cts_pkg and the core.
module tb_top;

    localparam int unsigned IDLE_PCT        = 12;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned RANDOM_EVENTS   = 1750;
    localparam int unsigned CONFIG_PHASES   = 7;
    // Index with no register behind it; writes there must change nothing
    localparam logic [i2cts_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // Function codes with no meaning
    localparam logic [i2cts_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [i2cts_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    // DUT connections
    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [i2cts_pkg::S_TDATA_W-1:0]     s_tdata   = '0;
    logic [i2cts_pkg::FUNC_W-1:0]        s_tuser   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [i2cts_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                                cfg_wr_en = 1'b0;
    logic [i2cts_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [i2cts_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

    // Predictor copy of registers and bus state
    logic [6:0]  slave_addr_reg;
    logic [7:0]  read_byte_reg;
    logic [7:0]  stored_dflt_reg;
    logic        bus_busy;
    logic        addressed;
    logic [6:0]  cur_target;
    logic        dir_read;
    logic [7:0]  rx_byte;
    logic [31:0] cnt_start, cnt_restart, cnt_stop, cnt_ack, cnt_nack, cnt_byte;

    // Results still owed by the DUT, oldest first
    i2cts_pkg::result_t pending_results[$];

    // Bookkeeping
    int unsigned events_sent     = 0;
    int unsigned events_applied  = 0;
    int unsigned regs_written    = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    bit          source_steady   = 1'b0;

    // Sink control: hold-off requests are counted so each side has one driver
    logic        sink_steady       = 1'b0;
    int unsigned hold_off_requests = 0;
    int unsigned hold_off_served   = 0;
    int unsigned hold_off_left     = 0;

    i2c_transaction_slave_model_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void bus_model_reset();
        slave_addr_reg  = '0;
        read_byte_reg   = '0;
        stored_dflt_reg = '0;
        bus_busy        = 1'b0;
        addressed       = 1'b0;
        cur_target      = '0;
        dir_read        = 1'b0;
        rx_byte         = '0;
        cnt_start       = '0;
        cnt_restart     = '0;
        cnt_stop        = '0;
        cnt_ack         = '0;
        cnt_nack        = '0;
        cnt_byte        = '0;
    endfunction

    function automatic void drop_transaction();
        addressed  = 1'b0;
        cur_target = '0;
        dir_read   = 1'b0;
    endfunction

    // Apply one bus event to the predicted state and return the result it gives
    function automatic i2cts_pkg::result_t bus_apply(input i2cts_pkg::event_t ev);
        i2cts_pkg::result_t r;
        r = '0;
        case (ev.func)
            i2cts_pkg::FN_START:
                if (!bus_busy)
                begin
                    bus_busy = 1'b1;
                    drop_transaction();
                    cnt_start += 32'd1;
                    r.accepted = 1'b1;
                end
            i2cts_pkg::FN_RESTART:
                if (bus_busy)
                begin
                    drop_transaction();
                    cnt_restart += 32'd1;
                    r.accepted = 1'b1;
                end
            i2cts_pkg::FN_STOP:
                if (bus_busy)
                begin
                    bus_busy = 1'b0;
                    drop_transaction();
                    cnt_stop += 32'd1;
                    r.accepted = 1'b1;
                end
            i2cts_pkg::FN_ADDRESS:
                if (bus_busy && ev.target_address <= 8'd127)
                begin
                    cnt_byte += 32'd1;
                    cur_target = ev.target_address[6:0];
                    dir_read   = ev.read_not_write;
                    if (ev.target_address[6:0] == slave_addr_reg)
                    begin
                        addressed = 1'b1;
                        cnt_ack += 32'd1;
                    end
                    else
                    begin
                        addressed = 1'b0;
                        cnt_nack += 32'd1;
                        r.slave_nack = 1'b1;
                    end
                    r.accepted = 1'b1;
                end
            i2cts_pkg::FN_WRITE:
                if (bus_busy && addressed && !dir_read && cur_target == slave_addr_reg)
                begin
                    rx_byte = ev.write_data;
                    cnt_byte += 32'd1;
                    cnt_ack += 32'd1;
                    r.accepted = 1'b1;
                end
            i2cts_pkg::FN_READ:
                if (bus_busy && addressed && dir_read && cur_target == slave_addr_reg)
                begin
                    r.rd_byte = read_byte_reg;
                    cnt_byte += 32'd1;
                    if (ev.master_nack)
                        cnt_nack += 32'd1;
                    else
                        cnt_ack += 32'd1;
                    r.accepted = 1'b1;
                end
            default:
                ;
        endcase
        r.held_byte   = rx_byte;
        r.starts      = cnt_start;
        r.restarts    = cnt_restart;
        r.stops       = cnt_stop;
        r.acks        = cnt_ack;
        r.nacks       = cnt_nack;
        r.bytes       = cnt_byte;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic i2cts_pkg::result_t unpack_result(
        input logic [i2cts_pkg::M_TDATA_W-1:0] d);
        i2cts_pkg::result_t r;
        r.accepted    = d[0];
        r.slave_nack  = d[1];
        r.rd_byte     = d[9:2];
        r.held_byte   = d[17:10];
        r.starts      = d[49:18];
        r.restarts    = d[81:50];
        r.stops       = d[113:82];
        r.acks        = d[145:114];
        r.nacks       = d[177:146];
        r.bytes       = d[209:178];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Every output transfer is compared with the oldest prediction
    always @(posedge clk)
    begin
        i2cts_pkg::result_t want;
        i2cts_pkg::result_t got;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer, m_tdata %0h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                got  = unpack_result(m_tdata);
                check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                check_field("slave_nack", 32'(want.slave_nack), 32'(got.slave_nack));
                check_field("byte read", 32'(want.rd_byte), 32'(got.rd_byte));
                check_field("last byte received", 32'(want.held_byte), 32'(got.held_byte));
                check_field("starts_seen", want.starts, got.starts);
                check_field("restarts_seen", want.restarts, got.restarts);
                check_field("stops_seen", want.stops, got.stops);
                check_field("acks_seen", want.acks, got.acks);
                check_field("nacks_seen", want.nacks, got.nacks);
                check_field("bytes_seen", want.bytes, got.bytes);
                results_checked++;
            end
        end
    end

    // Sink ready: random stalls, steady stretches and requested long hold-offs
    always @(posedge clk)
    begin
        if (hold_off_served != hold_off_requests)
        begin
            hold_off_served <= hold_off_requests;
            hold_off_left   <= HOLD_OFF_CYCLES;
            m_tready        <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
            m_tready      <= 1'b0;
        end
        else
            m_tready <= sink_steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one event, wait for its transfer, record the prediction
    task automatic send_event(input i2cts_pkg::event_t ev);
        i2cts_pkg::result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= ev.func;
        s_tdata  <= {6'b0, ev.master_nack, ev.write_data, ev.read_not_write, ev.target_address};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = bus_apply(ev);
        pending_results.push_back(r);
        events_sent++;
        if (r.accepted)
            events_applied++;
        // occasional one-cycle gap in the source
        if (!source_steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [i2cts_pkg::FUNC_W-1:0] fn, input logic [7:0] addr,
                           input logic rnw, input logic [7:0] wdata, input logic mnack);
        i2cts_pkg::event_t ev;
        ev.func           = fn;
        ev.target_address = addr;
        ev.read_not_write = rnw;
        ev.write_data     = wdata;
        ev.master_nack    = mnack;
        send_event(ev);
    endtask

    // Event of the given kind with every other field random
    task automatic send_any(input logic [i2cts_pkg::FUNC_W-1:0] fn);
        send_op(fn, 8'($urandom_range(255)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                1'($urandom_range(1)));
    endtask

    // Stop offering and wait until every result has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [i2cts_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            i2cts_pkg::CFG_SLAVE_ADDR:  slave_addr_reg = val[6:0];
            i2cts_pkg::CFG_READ_BYTE:   read_byte_reg  = val;
            i2cts_pkg::CFG_STORED_DFLT:
            begin
                stored_dflt_reg = val;
                rx_byte         = val;
            end
            default:
                ;
        endcase
        regs_written++;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] addr, input logic [7:0] rbyte,
                             input logic [7:0] dflt);
        settle();
        write_reg(i2cts_pkg::CFG_SLAVE_ADDR, addr);
        write_reg(i2cts_pkg::CFG_READ_BYTE, rbyte);
        write_reg(i2cts_pkg::CFG_STORED_DFLT, dflt);
    endtask

    // Mostly the slave's own address, sometimes another, rarely an illegal one
    function automatic logic [7:0] pick_target();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return {1'b0, slave_addr_reg};
        else if (roll < 90)
            return 8'($urandom_range(127));
        else
            return 8'($urandom_range(255, 128));
    endfunction

    // Well-formed transactions with random content, mixed with noise
    task automatic run_traffic(input int unsigned n_events);
        int unsigned stop_at;
        int unsigned segments;
        logic        rnw;
        stop_at = events_sent + n_events;
        while (events_sent < stop_at)
        begin
            if ($urandom_range(99) < 15)
                send_any(3'($urandom_range(7)));
            else
            begin
                send_any(i2cts_pkg::FN_START);
                segments = $urandom_range(1, 3);
                for (int unsigned i = 0; i < segments; i++)
                begin
                    if (i != 0)
                        send_any(i2cts_pkg::FN_RESTART);
                    rnw = 1'($urandom_range(1));
                    send_op(i2cts_pkg::FN_ADDRESS, pick_target(), rnw,
                            8'($urandom_range(255)), 1'($urandom_range(1)));
                    repeat ($urandom_range(0, 6))
                        send_op(rnw ? i2cts_pkg::FN_READ : i2cts_pkg::FN_WRITE,
                                8'($urandom_range(255)), 1'($urandom_range(1)),
                                8'($urandom_range(255)), $urandom_range(3) == 0);
                end
                // now and then the stop is left out
                if ($urandom_range(9) != 0)
                    send_any(i2cts_pkg::FN_STOP);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Legality checks straight after reset, slave answering at address 0
    task automatic test_legality_from_reset();
        send_any(i2cts_pkg::FN_WRITE);          // write on an idle bus
        send_any(i2cts_pkg::FN_STOP);           // stop on an idle bus
        send_any(i2cts_pkg::FN_RESTART);
        send_any(i2cts_pkg::FN_ADDRESS);
        send_any(i2cts_pkg::FN_START);
        send_any(i2cts_pkg::FN_START);          // start while busy
        send_op(i2cts_pkg::FN_ADDRESS, 8'h80, 1'b0, 8'h00, 1'b0);   // just above 7 bits
        send_op(i2cts_pkg::FN_ADDRESS, 8'hFF, 1'b1, 8'hFF, 1'b1);
        send_op(i2cts_pkg::FN_ADDRESS, 8'h00, 1'b0, 8'h00, 1'b0);   // matching write
        send_op(i2cts_pkg::FN_WRITE, 8'h00, 1'b0, 8'hFF, 1'b0);
        send_any(i2cts_pkg::FN_READ);           // wrong direction
        send_any(FN_SPARE_LO);
        send_any(FN_SPARE_HI);
        send_any(i2cts_pkg::FN_RESTART);
        send_any(i2cts_pkg::FN_WRITE);          // nobody addressed after restart
        send_op(i2cts_pkg::FN_ADDRESS, 8'h7F, 1'b1, 8'h00, 1'b0);   // other slave, NACK
        send_any(i2cts_pkg::FN_READ);
        send_op(i2cts_pkg::FN_ADDRESS, 8'h00, 1'b1, 8'h00, 1'b0);   // matching read
        send_op(i2cts_pkg::FN_READ, 8'h00, 1'b0, 8'h00, 1'b0);
        send_op(i2cts_pkg::FN_READ, 8'h00, 1'b0, 8'h00, 1'b1);      // master NACK
        send_any(i2cts_pkg::FN_STOP);
        send_any(i2cts_pkg::FN_READ);           // read after stop
        settle();
    endtask

    // Address register changed while a transaction is open
    task automatic test_live_address_change();
        configure(8'h15, 8'h5A, 8'h00);
        send_any(i2cts_pkg::FN_START);
        send_op(i2cts_pkg::FN_ADDRESS, 8'h15, 1'b0, 8'h00, 1'b0);
        settle();
        write_reg(i2cts_pkg::CFG_SLAVE_ADDR, 8'h16);
        send_any(i2cts_pkg::FN_WRITE);          // target no longer matches
        settle();
        write_reg(i2cts_pkg::CFG_SLAVE_ADDR, 8'h95);    // top bit dropped, back to 0x15
        write_reg(i2cts_pkg::CFG_STORED_DFLT, 8'hC3);   // reloads the received byte
        write_reg(CFG_SPARE, 8'hFF);            // no register behind it
        send_any(i2cts_pkg::FN_WRITE);
        send_any(i2cts_pkg::FN_STOP);
        settle();
    endtask

    // Register settings from one extreme to the other, random traffic in each
    task automatic test_config_sweep();
        for (int unsigned p = 0; p < CONFIG_PHASES; p++)
        begin
            case (p)
                0: configure(8'h00, 8'h00, 8'h00);
                1: configure(8'h7F, 8'hFF, 8'hFF);
                2: configure(8'hFF, 8'h00, 8'hFF);
                default: configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                                   8'($urandom_range(255)));
            endcase
            // one phase runs without any idling on either side
            source_steady = (p == 3);
            sink_steady  <= (p == 3);
            run_traffic(RANDOM_EVENTS / CONFIG_PHASES);
        end
        source_steady = 1'b0;
        sink_steady  <= 1'b0;
        settle();
    endtask

    // Long sink hold-off while the source keeps offering, so the core fills up
    task automatic test_output_backpressure();
        configure(8'($urandom_range(127)), 8'($urandom_range(255)), 8'($urandom_range(255)));
        hold_off_requests <= hold_off_requests + 1;
        source_steady = 1'b1;
        run_traffic(60);
        source_steady = 1'b0;
        settle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        bus_model_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_legality_from_reset();
        test_live_address_change();
        test_config_sweep();
        test_output_backpressure();
        settle();

        $display("Sent %0d bus events (%0d applied, %0d rejected) over %0d register writes,",
                 events_sent, events_applied, events_sent - events_applied, regs_written);
        $display("including a %0d-cycle output stall; %0d results compared, %0d field errors.",
                 HOLD_OFF_CYCLES, results_checked, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("i2c_transaction_slave_model_core: match");
        else
            $display("i2c_transaction_slave_model_core: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("i2c_transaction_slave_model_core: mismatch");
        $finish;
    end

endmodule
